[rtl/assert_macros.svh]
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on the rising clock, masked while reset is high.
`define PLI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on the rising clock, also during reset.
`define PLI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/pli_pkg.sv]
// Types and constants of the piecewise linear interpolator.
package pli_pkg;

   localparam int ANGLE_W = 16;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 5;
   localparam int DIV_W   = 32;
   localparam int DEN_W   = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_OOB   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] result_value;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/pli_ram.sv]
// Breakpoint storage: one write port, one registered read port.
module pli_ram
   import pli_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pli_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module pli_div
   import pli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output div_status_type   status
);
   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // shift in the next dividend bit, subtract when it fits
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `PLI_ASSERT(a_no_restart, start |-> !busy_ff, "divider started while busy")
   `PLI_ASSERT(a_done_after_busy, done_ff |-> $past(busy_ff), "done without a run")
   `PLI_ASSERT_ALWAYS(a_cnt_idle, (cnt_ff != '0) |-> busy_ff, "step count set while idle")

endmodule

[rtl/piecewise_linear_interpolator.sv]
// Top level of the piecewise linear interpolator: sequencer, table and divider.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------
//   req_     | in        | req_valid / req_stall  | op, angle, value
//   rsp_     | out       | rsp_valid / rsp_stall  | status, result_value, entry_count
//
// Clear, an unused op, a full insert or an empty query go from decode to finish.
// Insert runs a table read and compare loop over the entries with a larger
// angle, moving each up one slot, then writes the new entry in the gap.
// A query checks one entry a cycle over the single RAM read port, each entry
// checked from the registered read data after its read is issued. An
// interpolated query then runs the multiply and the 32-step serial divider.
// Reset is synchronous and clears only control state;
// the table needs no clearing pass. The response is registered, so a stalled
// result holds while the next transfer is taken in; that item waits to finish.
module piecewise_linear_interpolator
   import pli_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);
   `include "assert_macros.svh"

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_QRY_SCAN,
      ST_QRY_MUL,
      ST_QRY_DIV,
      ST_QRY_WAIT,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   req_payload_type         item_ff, item_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic [CNT_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                    hit_ff, hit_in;
   logic [VALUE_W-1:0]      hit_val_ff, hit_val_in;
   entry_type               prev_ff, prev_in;
   entry_type               next_ff, next_in;
   logic signed [33:0]      prod_ff, prod_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic                    neg_ff, neg_in;
   logic [1:0]              status_ff, status_in;
   logic [VALUE_W-1:0]      result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   // table port
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   entry_type               wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   entry_type               rd_data;

   // divider port
   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend;
   logic [DIV_W-1:0]        div_quotient;
   div_status_type          div_stat;

   // interpolation datapath
   logic signed [16:0]      dx, dv, da;
   logic [33:0]             prod_mag;
   logic [16:0]             q_mag;
   logic [16:0]             q_signed;
   logic [16:0]             interp_sum;
   logic                    x_below, x_above, x_equal;

   assign x_below = ($signed(item_ff.angle) < $signed(rd_data.angle));
   assign x_above = ($signed(item_ff.angle) > $signed(rd_data.angle));
   assign x_equal = (item_ff.angle == rd_data.angle);

   assign dx = {item_ff.angle[15], item_ff.angle} - {prev_ff.angle[15], prev_ff.angle};
   assign dv = {next_ff.value[15], next_ff.value} - {prev_ff.value[15], prev_ff.value};
   assign da = {next_ff.angle[15], next_ff.angle} - {prev_ff.angle[15], prev_ff.angle};

   // |num| < 2^32 since both factors are below 2^16 in magnitude
   assign prod_mag     = prod_ff[33] ? 34'(-prod_ff) : prod_ff;
   assign div_dividend = prod_mag[DIV_W-1:0];
   assign q_mag        = {1'b0, div_quotient[15:0]};
   assign q_signed     = neg_ff ? 17'(-q_mag) : q_mag;
   assign interp_sum   = {prev_ff.value[15], prev_ff.value} + q_signed;

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      hit_in         = hit_ff;
      hit_val_in     = hit_val_ff;
      prev_in        = prev_ff;
      next_in        = next_ff;
      prod_in        = prod_ff;
      den_in         = den_ff;
      neg_in         = neg_ff;
      status_in      = status_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = {item_ff.angle, item_ff.value};
      rd_addr        = '0;
      div_start      = 1'b0;

      // output transfer frees the response register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = STATUS_OK;
            result_in = '0;
            hit_in    = 1'b0;
            pend_in   = 1'b0;
            idx_in    = '0;
            state_in  = ST_FINISH;
            case (item_ff.op)
               OP_INSERT: begin
                  if (count_ff == DEPTH_CNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_INS_RD;
                  end
               end
               OP_QUERY: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     state_in = ST_QRY_SCAN;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         // insert: walk down from the top, moving larger angles up one slot
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               state_in = ST_INS_PUT;
            end else begin
               rd_addr  = ADDR_W'(idx_ff - 1'b1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (x_below) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[ADDR_W-1:0];
               wr_data  = rd_data;
               idx_in   = idx_ff - 1'b1;
               state_in = ST_INS_RD;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[ADDR_W-1:0];
            count_in = count_ff + 1'b1;
            state_in = ST_FINISH;
         end
         // query: one read issued a cycle, data checked from the registered read port
         ST_QRY_SCAN: begin
            if (idx_ff < count_ff) begin
               rd_addr     = idx_ff[ADDR_W-1:0];
               idx_in      = idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (pend_idx_ff == '0 && x_below) begin
                  status_in = STATUS_OOB;
                  state_in  = ST_FINISH;
               end else if (x_below) begin
                  // first angle above the query closes the bracket
                  next_in = rd_data;
                  if (hit_ff) begin
                     result_in = hit_val_ff;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in = ST_QRY_MUL;
                  end
               end else begin
                  prev_in = rd_data;
                  if (x_equal) begin
                     hit_in     = 1'b1;
                     hit_val_in = rd_data.value;
                  end
                  if (pend_idx_ff == CNT_W'(count_ff - 1'b1)) begin
                     state_in = ST_FINISH;
                     if (x_equal) begin
                        result_in = rd_data.value;
                     end else if (hit_ff) begin
                        result_in = hit_val_ff;
                     end else if (x_above) begin
                        status_in = STATUS_OOB;
                     end
                  end
               end
            end
         end
         ST_QRY_MUL: begin
            prod_in  = dx * dv;
            den_in   = da[DEN_W-1:0];
            state_in = ST_QRY_DIV;
         end
         ST_QRY_DIV: begin
            div_start = 1'b1;
            neg_in    = prod_ff[33];
            state_in  = ST_QRY_WAIT;
         end
         ST_QRY_WAIT: begin
            if (div_stat.done) begin
               result_in = interp_sum[VALUE_W-1:0];
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.status       = status_ff;
               rsp_payload_in.result_value = result_ff;
               rsp_payload_in.entry_count  = COUNT_W'(count_ff);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff        <= item_in;
      idx_ff         <= idx_in;
      pend_idx_ff    <= pend_idx_in;
      hit_val_ff     <= hit_val_in;
      prev_ff        <= prev_in;
      next_ff        <= next_in;
      prod_ff        <= prod_in;
      den_ff         <= den_in;
      neg_ff         <= neg_in;
      status_ff      <= status_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   pli_ram #(
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   pli_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (den_ff),
      .quotient(div_quotient),
      .status  (div_stat)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // terms for the checks below
   logic in_finish;
   logic finish_held;
   logic in_insert;

   assign in_finish   = (state_ff == ST_FINISH);
   assign finish_held = in_finish && rsp_valid_ff && rsp_stall;
   assign in_insert   = (state_ff == ST_INS_CMP || state_ff == ST_INS_PUT);

   `PLI_ASSERT(a_count_bound, count_ff <= DEPTH_CNT, "entry count above table depth")
   `PLI_ASSERT(a_finish_holds, finish_held |=> in_finish, "result dropped while output busy")
   `PLI_ASSERT(a_write_in_insert, wr_en |-> in_insert, "table written outside insert")

endmodule
